[src/usf_pkg.sv]
package usf_pkg;

    localparam int CFG_DIM_W  = 11;
    localparam int EPS_W      = 16;
    localparam int SAMPLE_W   = 18;
    localparam int VAL_W      = 17;
    localparam int KEY_W      = 42;
    localparam int CIDX_W     = 20;
    localparam int KEY_SHIFT  = 24;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIE_EPSILON  = 2'd2;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET   = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET  = 11'd1024;
    localparam logic [EPS_W-1:0]     EPSILON_RESET = 16'd1;

    localparam logic [VAL_W-1:0] ONE_VALUE = 17'd65536;
    // -2^38 as a 42-bit two's complement word
    localparam logic [KEY_W-1:0] KEY_MIN   = 42'h3C000000000;
    // 2^38, headroom below zero before the key saturates
    localparam logic [40:0]      KEY_SLACK = 41'h04000000000;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_HEDGE  = 2'd1,
        KIND_VEDGE  = 2'd2,
        KIND_FACE   = 2'd3
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t         kind;
        logic               last;
        logic [VAL_W-1:0]   mval;
    } cell_ctl_t;

    function automatic logic [VAL_W-1:0] clamp_sample(input logic signed [SAMPLE_W-1:0] s);
        logic [VAL_W-1:0] r;
        if (s[SAMPLE_W-1]) begin
            r = '0;
        end else if (s > $signed({1'b0, ONE_VALUE})) begin
            r = ONE_VALUE;
        end else begin
            r = s[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

[src/usf_line_buf.sv]
module usf_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [AW-1:0]                addr,
    input  logic [usf_pkg::VAL_W-1:0]    wdata,
    output logic [usf_pkg::VAL_W-1:0]    rdata
);

    logic [usf_pkg::VAL_W-1:0] mem [DEPTH];
    logic [usf_pkg::VAL_W-1:0] rdata_reg;

    // read-first: the old row's value comes out while this row's value goes in
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/usf_cell_seq.sv]
module usf_cell_seq #(
    parameter int YC_W  = 10,
    parameter int WX_W  = 11,
    parameter int IDX_W = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         load,
    input  logic [usf_pkg::VAL_W-1:0]    in_cur,
    input  logic                         in_has_h,
    input  logic                         in_has_v,
    input  logic [IDX_W-1:0]             in_p,
    input  logic [YC_W-1:0]              in_y,
    input  logic [WX_W-1:0]              w_eff,
    input  logic [usf_pkg::VAL_W-1:0]    above,
    output logic                         pix_done,
    output logic                         c1_valid,
    output usf_pkg::cell_ctl_t           c1_ctl,
    output logic [IDX_W-1:0]             c1_idx
);

    logic                          s1_valid_reg;
    usf_pkg::cell_kind_t           kind_reg;
    logic [usf_pkg::VAL_W-1:0]     cur_reg;
    logic                          has_h_reg;
    logic                          has_v_reg;
    logic [IDX_W-1:0]              p_reg;
    logic [YC_W-1:0]               y_reg;
    logic [usf_pkg::VAL_W-1:0]     left_reg;
    logic [usf_pkg::VAL_W-1:0]     ul_reg;

    logic                          c1_valid_reg;
    usf_pkg::cell_ctl_t            c1_ctl_reg;
    logic [IDX_W-1:0]              c1_idx_reg;

    usf_pkg::cell_kind_t           kind_next;
    logic                          last_now;
    logic [usf_pkg::VAL_W-1:0]     above_m;
    logic [IDX_W-1:0]              idx_now;
    logic [usf_pkg::VAL_W-1:0]     mval_now;
    logic [IDX_W-1:0]              w_ext;
    logic [IDX_W-1:0]              y_ext;

    assign above_m = has_v_reg ? above : '0;
    assign w_ext   = IDX_W'(w_eff);
    assign y_ext   = IDX_W'(y_reg);

    always_comb begin
        kind_next = kind_reg;
        last_now  = 1'b1;
        idx_now   = p_reg;
        mval_now  = cur_reg;
        unique case (kind_reg)
            usf_pkg::KIND_VERTEX: begin
                idx_now  = p_reg;
                mval_now = cur_reg;
                if (has_h_reg) begin
                    kind_next = usf_pkg::KIND_HEDGE;
                    last_now  = 1'b0;
                end else if (has_v_reg) begin
                    kind_next = usf_pkg::KIND_VEDGE;
                    last_now  = 1'b0;
                end
            end
            usf_pkg::KIND_HEDGE: begin
                idx_now  = p_reg - y_ext - IDX_W'(1);
                mval_now = usf_pkg::min_val(left_reg, cur_reg);
                if (has_v_reg) begin
                    kind_next = usf_pkg::KIND_VEDGE;
                    last_now  = 1'b0;
                end
            end
            usf_pkg::KIND_VEDGE: begin
                idx_now  = p_reg - w_ext;
                mval_now = usf_pkg::min_val(above_m, cur_reg);
                if (has_h_reg) begin
                    kind_next = usf_pkg::KIND_FACE;
                    last_now  = 1'b0;
                end
            end
            usf_pkg::KIND_FACE: begin
                idx_now  = p_reg - w_ext - y_ext;
                mval_now = usf_pkg::min_val(usf_pkg::min_val(ul_reg, above_m),
                                            usf_pkg::min_val(left_reg, cur_reg));
            end
        endcase
    end

    assign pix_done = !s1_valid_reg || last_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            kind_reg     <= usf_pkg::KIND_VERTEX;
            left_reg     <= '0;
            ul_reg       <= '0;
            c1_valid_reg <= 1'b0;
        end else if (adv) begin
            c1_valid_reg <= s1_valid_reg;
            if (s1_valid_reg && last_now) begin
                left_reg <= cur_reg;
                ul_reg   <= above_m;
            end
            if (load) begin
                s1_valid_reg <= 1'b1;
                kind_reg     <= usf_pkg::KIND_VERTEX;
            end else if (last_now) begin
                s1_valid_reg <= 1'b0;
            end else begin
                kind_reg     <= kind_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg   <= in_cur;
            has_h_reg <= in_has_h;
            has_v_reg <= in_has_v;
            p_reg     <= in_p;
            y_reg     <= in_y;
        end
        if (adv) begin
            c1_ctl_reg.kind <= kind_reg;
            c1_ctl_reg.last <= last_now;
            c1_ctl_reg.mval <= mval_now;
            c1_idx_reg      <= idx_now;
        end
    end

    assign c1_valid = c1_valid_reg;
    assign c1_ctl   = c1_ctl_reg;
    assign c1_idx   = c1_idx_reg;

endmodule

[src/usf_key_pipe.sv]
module usf_key_pipe #(
    parameter int IDX_W = 20,
    parameter int GID_W = 23
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             c1_valid,
    input  usf_pkg::cell_ctl_t               c1_ctl,
    input  logic [IDX_W-1:0]                 c1_idx,
    input  logic [GID_W-1:0]                 base_h,
    input  logic [GID_W-1:0]                 base_v,
    input  logic [GID_W-1:0]                 base_f,
    input  logic [usf_pkg::EPS_W-1:0]        eps,
    output logic                             m_valid,
    output logic [1:0]                       m_cell_kind,
    output logic [usf_pkg::CIDX_W-1:0]       m_cell_index,
    output logic signed [usf_pkg::KEY_W-1:0] m_cell_key,
    output logic [usf_pkg::VAL_W-1:0]        m_corner_min,
    output logic                             m_last_of_pixel
);

    localparam int PROD_W = usf_pkg::EPS_W + GID_W;
    localparam int EXT_W  = (PROD_W > usf_pkg::KEY_W) ? PROD_W : usf_pkg::KEY_W;

    logic                          c2_valid_reg;
    usf_pkg::cell_ctl_t            c2_ctl_reg;
    logic [IDX_W-1:0]              c2_idx_reg;
    logic [GID_W-1:0]              c2_gid1_reg;

    logic                          c3_valid_reg;
    usf_pkg::cell_ctl_t            c3_ctl_reg;
    logic [IDX_W-1:0]              c3_idx_reg;
    logic [PROD_W-1:0]             c3_prod_reg;

    logic                          out_valid_reg;
    logic [1:0]                    out_kind_reg;
    logic [usf_pkg::CIDX_W-1:0]    out_idx_reg;
    logic [usf_pkg::KEY_W-1:0]     out_key_reg;
    logic [usf_pkg::VAL_W-1:0]     out_min_reg;
    logic                          out_last_reg;

    logic [GID_W-1:0]              base_sel;
    logic [GID_W-1:0]              gid1_next;
    logic [PROD_W-1:0]             prod_next;
    logic [EXT_W-1:0]              scaled;
    logic [EXT_W-1:0]              thresh;
    logic [EXT_W-1:0]              prod_ext;
    logic                          sat;
    logic [usf_pkg::KEY_W-1:0]     key_next;

    always_comb begin
        case (c1_ctl.kind)
            usf_pkg::KIND_HEDGE: base_sel = base_h;
            usf_pkg::KIND_VEDGE: base_sel = base_v;
            usf_pkg::KIND_FACE:  base_sel = base_f;
            default:             base_sel = '0;
        endcase
    end

    assign gid1_next = GID_W'(c1_idx) + base_sel + GID_W'(1);
    assign prod_next = PROD_W'(eps) * PROD_W'(c2_gid1_reg);

    assign scaled   = EXT_W'({c3_ctl_reg.mval, {usf_pkg::KEY_SHIFT{1'b0}}});
    assign thresh   = scaled + EXT_W'(usf_pkg::KEY_SLACK);
    assign prod_ext = EXT_W'(c3_prod_reg);
    assign sat      = prod_ext > thresh;
    assign key_next = sat ? usf_pkg::KEY_MIN : usf_pkg::KEY_W'(scaled - prod_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_valid_reg  <= 1'b0;
            c3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            c2_valid_reg  <= c1_valid;
            c3_valid_reg  <= c2_valid_reg;
            out_valid_reg <= c3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c2_ctl_reg   <= c1_ctl;
            c2_idx_reg   <= c1_idx;
            c2_gid1_reg  <= gid1_next;
            c3_ctl_reg   <= c2_ctl_reg;
            c3_idx_reg   <= c2_idx_reg;
            c3_prod_reg  <= prod_next;
            out_kind_reg <= c3_ctl_reg.kind;
            out_idx_reg  <= usf_pkg::CIDX_W'(c3_idx_reg);
            out_key_reg  <= key_next;
            out_min_reg  <= c3_ctl_reg.mval;
            out_last_reg <= c3_ctl_reg.last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_cell_kind     = out_kind_reg;
    assign m_cell_index    = out_idx_reg;
    assign m_cell_key      = $signed(out_key_reg);
    assign m_corner_min    = out_min_reg;
    assign m_last_of_pixel = out_last_reg;

endmodule

[src/upper_star_filtration_2d.sv]
// The first cell of a pixel passes the cell sequencer, then the c1, c2, c3 and output registers.
// Throughput: one cell per cycle while m_ready does not stall the output; a pixel holds the
// cell sequencer until it has issued its last cell (one to four cells, all four in a frame interior).
// Reset: synchronous, active low; clears position, neighbour registers and all
// valid flags. The line buffer is not cleared; each row overwrites it in place.
module upper_star_filtration_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [usf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [usf_pkg::EPS_W-1:0]            cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [usf_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_cell_kind,
    output logic [usf_pkg::CIDX_W-1:0]           m_cell_index,
    output logic signed [usf_pkg::KEY_W-1:0]     m_cell_key,
    output logic [usf_pkg::VAL_W-1:0]            m_corner_min,
    output logic                                 m_last_of_pixel
);

    localparam int XC_W  = $clog2(MAX_WIDTH);
    localparam int YC_W  = $clog2(MAX_HEIGHT);
    localparam int WX_W  = $clog2(MAX_WIDTH + 1);
    localparam int HX_W  = $clog2(MAX_HEIGHT + 1);
    localparam int IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int GID_W = $clog2(4 * MAX_WIDTH * MAX_HEIGHT + 1);

    logic [usf_pkg::CFG_DIM_W-1:0] width_reg;
    logic [usf_pkg::CFG_DIM_W-1:0] height_reg;
    logic [usf_pkg::EPS_W-1:0]     eps_reg;

    logic [XC_W-1:0]  x_reg;
    logic [YC_W-1:0]  y_reg;
    logic [IDX_W-1:0] p_reg;

    logic [GID_W-1:0] nv_reg;
    logic [GID_W-1:0] bv_reg;
    logic [GID_W-1:0] bf_reg;

    logic [WX_W-1:0]  w_eff;
    logic [HX_W-1:0]  h_eff;
    logic             x_last;
    logic             y_last;
    logic             geom_wr;

    logic             adv;
    logic             pix_done;
    logic             accept;
    logic [usf_pkg::VAL_W-1:0] cur_in;
    logic [usf_pkg::VAL_W-1:0] above;

    logic                      c1_valid;
    usf_pkg::cell_ctl_t        c1_ctl;
    logic [IDX_W-1:0]          c1_idx;

    assign w_eff = (width_reg == '0) ? WX_W'(1) :
                   ((32'(width_reg) > MAX_WIDTH) ? WX_W'(MAX_WIDTH) : WX_W'(width_reg));
    assign h_eff = (height_reg == '0) ? HX_W'(1) :
                   ((32'(height_reg) > MAX_HEIGHT) ? HX_W'(MAX_HEIGHT) : HX_W'(height_reg));

    assign x_last = ((WX_W + 1)'(x_reg) + (WX_W + 1)'(1)) >= (WX_W + 1)'(w_eff);
    assign y_last = ((HX_W + 1)'(y_reg) + (HX_W + 1)'(1)) >= (HX_W + 1)'(h_eff);

    assign geom_wr = cfg_wr_en &&
                     (cfg_addr == usf_pkg::REG_IMAGE_WIDTH ||
                      cfg_addr == usf_pkg::REG_IMAGE_HEIGHT);

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && pix_done;
    assign accept  = s_valid && s_ready;
    assign cur_in  = usf_pkg::clamp_sample(s_sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= usf_pkg::WIDTH_RESET;
            height_reg <= usf_pkg::HEIGHT_RESET;
            eps_reg    <= usf_pkg::EPSILON_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                usf_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[usf_pkg::CFG_DIM_W-1:0];
                usf_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[usf_pkg::CFG_DIM_W-1:0];
                usf_pkg::REG_TIE_EPSILON:  eps_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
            p_reg <= '0;
        end else if (geom_wr) begin
            x_reg <= '0;
            y_reg <= '0;
            p_reg <= '0;
        end else if (accept) begin
            if (x_last) begin
                x_reg <= '0;
                if (y_last) begin
                    y_reg <= '0;
                    p_reg <= '0;
                end else begin
                    y_reg <= y_reg + YC_W'(1);
                    p_reg <= p_reg + IDX_W'(1);
                end
            end else begin
                x_reg <= x_reg + XC_W'(1);
                p_reg <= p_reg + IDX_W'(1);
            end
        end
    end

    // block bases of the global id space, refreshed every cycle from the geometry
    always_ff @(posedge aclk) begin
        nv_reg <= GID_W'(w_eff) * GID_W'(h_eff);
        bv_reg <= (nv_reg << 1) - GID_W'(h_eff);
        bf_reg <= nv_reg + (nv_reg << 1) - GID_W'(h_eff) - GID_W'(w_eff);
    end

    usf_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (XC_W)
    ) u_line_buf (
        .aclk  (aclk),
        .en    (accept),
        .addr  (x_reg),
        .wdata (cur_in),
        .rdata (above)
    );

    usf_cell_seq #(
        .YC_W  (YC_W),
        .WX_W  (WX_W),
        .IDX_W (IDX_W)
    ) u_cell_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .load     (accept),
        .in_cur   (cur_in),
        .in_has_h (x_reg != '0),
        .in_has_v (y_reg != '0),
        .in_p     (p_reg),
        .in_y     (y_reg),
        .w_eff    (w_eff),
        .above    (above),
        .pix_done (pix_done),
        .c1_valid (c1_valid),
        .c1_ctl   (c1_ctl),
        .c1_idx   (c1_idx)
    );

    usf_key_pipe #(
        .IDX_W (IDX_W),
        .GID_W (GID_W)
    ) u_key_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .c1_valid        (c1_valid),
        .c1_ctl          (c1_ctl),
        .c1_idx          (c1_idx),
        .base_h          (nv_reg),
        .base_v          (bv_reg),
        .base_f          (bf_reg),
        .eps             (eps_reg),
        .m_valid         (m_valid),
        .m_cell_kind     (m_cell_kind),
        .m_cell_index    (m_cell_index),
        .m_cell_key      (m_cell_key),
        .m_corner_min    (m_corner_min),
        .m_last_of_pixel (m_last_of_pixel)
    );

endmodule

[src/usf_checker.sv]
module usf_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [1:0]                           m_cell_kind,
    input logic [usf_pkg::CIDX_W-1:0]           m_cell_index,
    input logic signed [usf_pkg::KEY_W-1:0]     m_cell_key,
    input logic [usf_pkg::VAL_W-1:0]            m_corner_min,
    input logic                                 m_last_of_pixel
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled transaction holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_kind) && $stable(m_cell_index)
                                && $stable(m_cell_key) && $stable(m_corner_min)
                                && $stable(m_last_of_pixel))
        else $error("stalled result changed");

    // the face is always the final cell of its pixel
    a_face_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cell_kind == usf_pkg::KIND_FACE |-> m_last_of_pixel)
        else $error("face not marked last of pixel");

    // corner minimum stays within the clamp range
    a_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_corner_min <= usf_pkg::ONE_VALUE)
        else $error("corner minimum out of range");

    // the tie-break only ever lowers the key
    a_key_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cell_key <= $signed({1'b0, m_corner_min, 24'd0}))
        else $error("key above its unperturbed value");

endmodule

bind upper_star_filtration_2d usf_checker u_usf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cell_kind     (m_cell_kind),
    .m_cell_index    (m_cell_index),
    .m_cell_key      (m_cell_key),
    .m_corner_min    (m_corner_min),
    .m_last_of_pixel (m_last_of_pixel)
);
